// ----- rtl/hrp_pkg.sv -----
package hrp_pkg;

   // default depth of the value store
   localparam int TOKEN_BYTES_DEF = 32;

   // field widths
   localparam int LEN_W  = 5;
   localparam int KIND_W = 3;

   // key length that can match content-length
   localparam int MATCH_LEN = 14;

   // byte classes
   localparam logic [2:0] CLS_OTHER = 3'd0;
   localparam logic [2:0] CLS_TAB   = 3'd1;
   localparam logic [2:0] CLS_LF    = 3'd2;
   localparam logic [2:0] CLS_CR    = 3'd3;
   localparam logic [2:0] CLS_SPACE = 3'd4;
   localparam logic [2:0] CLS_COMMA = 3'd5;
   localparam logic [2:0] CLS_COLON = 3'd6;

   localparam logic [3:0] NUM_STATES = 4'd11;

   // transition entries that carry an action
   localparam logic [7:0] ENT_END_OK      = 8'hC0;
   localparam logic [7:0] ENT_END_BAD     = 8'hC1;
   localparam logic [7:0] ENT_STORE       = 8'hC4;
   localparam logic [7:0] ENT_VERSION     = 8'h80;
   localparam logic [7:0] ENT_CODE        = 8'h81;
   localparam logic [7:0] ENT_REASON      = 8'h82;
   localparam logic [7:0] ENT_KEY         = 8'h84;
   localparam logic [7:0] ENT_VALUE       = 8'h87;
   localparam logic [7:0] ENT_VALUE_SPLIT = 8'h88;

   // event kinds
   localparam logic [KIND_W-1:0] EV_CONTINUE = 3'd0;
   localparam logic [KIND_W-1:0] EV_VERSION  = 3'd1;
   localparam logic [KIND_W-1:0] EV_CODE     = 3'd2;
   localparam logic [KIND_W-1:0] EV_REASON   = 3'd3;
   localparam logic [KIND_W-1:0] EV_KEY      = 3'd4;
   localparam logic [KIND_W-1:0] EV_VALUE    = 3'd5;
   localparam logic [KIND_W-1:0] EV_STORED   = 3'd6;
   localparam logic [KIND_W-1:0] EV_DONE     = 3'd7;

   // rows: parse state, columns: byte class
   localparam logic [7:0] STEP_TABLE [0:10][0:6] = '{
      '{8'h80, 8'h01, 8'hC1, 8'hC1, 8'h01, 8'h80, 8'h80},
      '{8'h81, 8'h02, 8'hC1, 8'hC1, 8'h02, 8'h01, 8'h01},
      '{8'h82, 8'h82, 8'h04, 8'h03, 8'h82, 8'h82, 8'h82},
      '{8'hC1, 8'hC1, 8'h04, 8'hC1, 8'hC1, 8'hC1, 8'hC1},
      '{8'h84, 8'hC1, 8'hC0, 8'h05, 8'hC1, 8'hC1, 8'h06},
      '{8'hC1, 8'hC1, 8'hC0, 8'hC1, 8'hC1, 8'hC1, 8'hC1},
      '{8'h87, 8'h06, 8'hC1, 8'hC1, 8'h06, 8'h87, 8'h87},
      '{8'h87, 8'h87, 8'hC4, 8'h0A, 8'h87, 8'h88, 8'h87},
      '{8'h87, 8'h88, 8'h06, 8'h09, 8'h88, 8'h88, 8'h87},
      '{8'hC1, 8'hC1, 8'h06, 8'hC1, 8'hC1, 8'hC1, 8'hC1},
      '{8'hC1, 8'hC1, 8'hC4, 8'hC1, 8'hC1, 8'hC1, 8'hC1}
   };

   function automatic logic [2:0] byte_class(input logic [7:0] c);
      case (c)
         8'h09:   return CLS_TAB;
         8'h0A:   return CLS_LF;
         8'h0D:   return CLS_CR;
         8'h20:   return CLS_SPACE;
         8'h2C:   return CLS_COMMA;
         8'h3A:   return CLS_COLON;
         default: return CLS_OTHER;
      endcase
   endfunction

   // unused states end the headers as an error
   function automatic logic [7:0] step_entry(input logic [3:0] st, input logic [2:0] cls);
      if (st < NUM_STATES && cls <= CLS_COLON) begin
         return STEP_TABLE[st][cls];
      end
      return ENT_END_BAD;
   endfunction

   // "content-length", one character per index
   function automatic logic [7:0] match_char(input logic [3:0] idx);
      case (idx)
         4'd0:    return 8'h63;
         4'd1:    return 8'h6F;
         4'd2:    return 8'h6E;
         4'd3:    return 8'h74;
         4'd4:    return 8'h65;
         4'd5:    return 8'h6E;
         4'd6:    return 8'h74;
         4'd7:    return 8'h2D;
         4'd8:    return 8'h6C;
         4'd9:    return 8'h65;
         4'd10:   return 8'h6E;
         4'd11:   return 8'h67;
         4'd12:   return 8'h74;
         4'd13:   return 8'h68;
         default: return 8'h00;
      endcase
   endfunction

endpackage

// ----- rtl/hrp_digit_unit.sv -----
module hrp_digit_unit
   import hrp_pkg::*;
(
   input  logic [31:0] acc,
   input  logic [7:0]  char_code,
   output logic [31:0] result
);

   logic [31:0] char_ext;
   logic [31:0] times_ten;

   // byte counts as a signed char
   assign char_ext  = {{24{char_code[7]}}, char_code};
   // acc * 10 as two shifts and one add
   assign times_ten = {acc[28:0], 3'b000} + {acc[30:0], 1'b0};
   assign result    = times_ten + char_ext - 32'd48;

endmodule

// ----- rtl/hrp_value_store.sv -----
module hrp_value_store
   import hrp_pkg::*;
#(
   parameter int TOKEN_BYTES = TOKEN_BYTES_DEF,
   localparam int IDX_W = $clog2(TOKEN_BYTES)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [7:0]       wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [7:0]       rd_data
);

   logic [7:0] mem_ff [TOKEN_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/http_response_header_parser.sv -----
// a captured byte is decoded and its result loaded into the output register when free;
//    a new byte is taken only after that load. A value end after a content-length key
//    first walks the stored digits (a store read then a digit step per digit); the walk
//    shares one digit unit with the status code and reads one store port
// reset: synchronous, active high; clears the parser state and the accumulators,
//    the value store is not cleared
module http_response_header_parser
   import hrp_pkg::*;
#(
   parameter int TOKEN_BYTES = TOKEN_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // byte input channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_in_char,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [KIND_W-1:0]  rsp_event_kind,
   output logic [7:0]         rsp_out_char,
   output logic               rsp_key_closed,
   output logic [LEN_W-1:0]   rsp_key_len,
   output logic               rsp_value_closed,
   output logic [LEN_W-1:0]   rsp_value_len,
   output logic               rsp_headers_done,
   output logic               rsp_bad_end,
   output logic signed [31:0] rsp_status_code,
   output logic signed [31:0] rsp_content_length
);

   localparam int CNT_W   = $clog2(TOKEN_BYTES);
   localparam int KEY_CAP = TOKEN_BYTES - 1;
   localparam int VAL_CAP = TOKEN_BYTES - 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_WALK_RD,
      ST_WALK_ACC,
      ST_EMIT
   } seq_state_type;

   seq_state_type state_ff;

   // parser state
   logic [3:0]       parse_state_ff;
   logic [31:0]      code_acc_ff;
   logic [31:0]      length_acc_ff;
   logic [CNT_W-1:0] key_count_ff;
   logic             key_prefix_ok_ff;
   logic [CNT_W-1:0] value_count_ff;
   logic             length_pending_ff;

   // captured byte and the walk over the store
   logic [7:0]       in_char_ff;
   logic [CNT_W-1:0] walk_idx_ff;
   logic [CNT_W-1:0] walk_last_ff;

   // result fields held until the output register is free
   logic [KIND_W-1:0] res_kind_ff;
   logic [7:0]        res_char_ff;
   logic              res_kclosed_ff;
   logic [LEN_W-1:0]  res_klen_ff;
   logic              res_vclosed_ff;
   logic [LEN_W-1:0]  res_vlen_ff;
   logic              res_done_ff;
   logic              res_bad_ff;

   // output register
   logic               rsp_valid_ff;
   logic [KIND_W-1:0]  rsp_event_kind_ff;
   logic [7:0]         rsp_out_char_ff;
   logic               rsp_key_closed_ff;
   logic [LEN_W-1:0]   rsp_key_len_ff;
   logic               rsp_value_closed_ff;
   logic [LEN_W-1:0]   rsp_value_len_ff;
   logic               rsp_headers_done_ff;
   logic               rsp_bad_end_ff;
   logic signed [31:0] rsp_status_code_ff;
   logic signed [31:0] rsp_content_length_ff;

   logic [7:0]  entry;
   logic [7:0]  key_char;
   logic        is_value;
   logic [31:0] unit_acc;
   logic [7:0]  unit_char;
   logic [31:0] unit_result;
   logic [7:0]  store_rd_data;
   logic        out_free;

   // table step for the captured byte
   assign entry = step_entry(parse_state_ff, byte_class(in_char_ff));

   // lowercase, A-Z only
   assign key_char = (in_char_ff >= 8'h41 && in_char_ff <= 8'h5A) ?
                     (in_char_ff + 8'h20) : in_char_ff;

   assign is_value = (entry == ENT_VALUE) || (entry == ENT_VALUE_SPLIT);

   // the digit unit serves the status code in decode and the length during the walk
   assign unit_acc  = (state_ff == ST_WALK_ACC) ? length_acc_ff : code_acc_ff;
   assign unit_char = (state_ff == ST_WALK_ACC) ? store_rd_data : in_char_ff;

   hrp_digit_unit u_digit (
      .acc       (unit_acc),
      .char_code (unit_char),
      .result    (unit_result)
   );

   // value bytes are written at decode, read back one per walk step
   hrp_value_store #(
      .TOKEN_BYTES (TOKEN_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (state_ff == ST_DECODE && is_value),
      .wr_addr (value_count_ff),
      .wr_data (in_char_ff),
      .rd_addr (walk_idx_ff),
      .rd_data (store_rd_data)
   );

   // output register can load when empty or emptying this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         rsp_valid_ff      <= 1'b0;
         parse_state_ff    <= 4'd0;
         code_acc_ff       <= 32'd0;
         length_acc_ff     <= 32'd0;
         key_count_ff      <= '0;
         key_prefix_ok_ff  <= 1'b1;
         value_count_ff    <= '0;
         length_pending_ff <= 1'b0;
      end else begin
         // result transfer frees the output register
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  in_char_ff <= req_in_char;
                  state_ff   <= ST_DECODE;
               end
            end

            ST_DECODE: begin
               parse_state_ff <= entry[3:0];
               res_kind_ff    <= EV_CONTINUE;
               res_char_ff    <= in_char_ff;
               res_kclosed_ff <= 1'b0;
               res_klen_ff    <= '0;
               res_vclosed_ff <= 1'b0;
               res_vlen_ff    <= '0;
               res_done_ff    <= 1'b0;
               res_bad_ff     <= 1'b0;
               state_ff       <= ST_EMIT;

               unique case (entry) inside
                  ENT_END_OK, ENT_END_BAD: begin
                     res_kind_ff <= EV_DONE;
                     res_done_ff <= 1'b1;
                     res_bad_ff  <= (entry == ENT_END_BAD);
                  end
                  ENT_VERSION: begin
                     res_kind_ff <= EV_VERSION;
                  end
                  ENT_CODE: begin
                     res_kind_ff <= EV_CODE;
                     code_acc_ff <= unit_result;
                  end
                  ENT_REASON: begin
                     res_kind_ff <= EV_REASON;
                  end
                  ENT_KEY: begin
                     res_kind_ff <= EV_KEY;
                     res_char_ff <= key_char;
                     // characters past the cap are reported but not counted
                     if (key_count_ff < CNT_W'(KEY_CAP)) begin
                        if (key_count_ff < CNT_W'(MATCH_LEN) &&
                            key_char != match_char(key_count_ff[3:0])) begin
                           key_prefix_ok_ff <= 1'b0;
                        end
                        key_count_ff <= key_count_ff + CNT_W'(1);
                     end
                  end
                  ENT_VALUE, ENT_VALUE_SPLIT: begin
                     res_kind_ff <= EV_VALUE;
                     // first value byte closes the key
                     if (key_count_ff != '0) begin
                        res_kclosed_ff <= 1'b1;
                        res_klen_ff    <= LEN_W'(key_count_ff);
                        if (key_count_ff == CNT_W'(MATCH_LEN) && key_prefix_ok_ff) begin
                           length_pending_ff <= 1'b1;
                        end
                        key_count_ff     <= '0;
                        key_prefix_ok_ff <= 1'b1;
                     end
                     // at the cap slot VAL_CAP (TOKEN_BYTES - 2) keeps being overwritten
                     if (value_count_ff < CNT_W'(VAL_CAP)) begin
                        value_count_ff <= value_count_ff + CNT_W'(1);
                     end
                  end
                  ENT_STORE: begin
                     res_kind_ff <= EV_STORED;
                     if (value_count_ff != '0) begin
                        res_vclosed_ff <= 1'b1;
                        res_vlen_ff    <= LEN_W'(value_count_ff);
                        value_count_ff <= '0;
                        // content-length value: walk the stored digits
                        if (length_pending_ff) begin
                           length_pending_ff <= 1'b0;
                           walk_idx_ff       <= '0;
                           walk_last_ff      <= value_count_ff - CNT_W'(1);
                           state_ff          <= ST_WALK_RD;
                        end
                     end
                  end
                  default: begin
                     res_kind_ff <= EV_CONTINUE;
                  end
               endcase
            end

            // store read of the current digit lands at the next edge
            ST_WALK_RD: begin
               state_ff <= ST_WALK_ACC;
            end

            ST_WALK_ACC: begin
               length_acc_ff <= unit_result;
               walk_idx_ff   <= walk_idx_ff + CNT_W'(1);
               if (walk_idx_ff == walk_last_ff) begin
                  state_ff <= ST_EMIT;
               end else begin
                  state_ff <= ST_WALK_RD;
               end
            end

            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff          <= 1'b1;
                  rsp_event_kind_ff     <= res_kind_ff;
                  rsp_out_char_ff       <= res_char_ff;
                  rsp_key_closed_ff     <= res_kclosed_ff;
                  rsp_key_len_ff        <= res_klen_ff;
                  rsp_value_closed_ff   <= res_vclosed_ff;
                  rsp_value_len_ff      <= res_vlen_ff;
                  rsp_headers_done_ff   <= res_done_ff;
                  rsp_bad_end_ff        <= res_bad_ff;
                  rsp_status_code_ff    <= code_acc_ff;
                  rsp_content_length_ff <= length_acc_ff;
                  // end of headers: parser returns to its reset state
                  if (res_done_ff) begin
                     parse_state_ff    <= 4'd0;
                     code_acc_ff       <= 32'd0;
                     length_acc_ff     <= 32'd0;
                     key_count_ff      <= '0;
                     key_prefix_ok_ff  <= 1'b1;
                     value_count_ff    <= '0;
                     length_pending_ff <= 1'b0;
                  end
                  state_ff <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // a new byte transfer only between items
   assign req_stall = (state_ff != ST_IDLE);

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_kind     = rsp_event_kind_ff;
   assign rsp_out_char       = rsp_out_char_ff;
   assign rsp_key_closed     = rsp_key_closed_ff;
   assign rsp_key_len        = rsp_key_len_ff;
   assign rsp_value_closed   = rsp_value_closed_ff;
   assign rsp_value_len      = rsp_value_len_ff;
   assign rsp_headers_done   = rsp_headers_done_ff;
   assign rsp_bad_end        = rsp_bad_end_ff;
   assign rsp_status_code    = rsp_status_code_ff;
   assign rsp_content_length = rsp_content_length_ff;

endmodule
